### design/dii_pkg.sv
// ----------------------------------------------------------------------------
// dii_pkg
// Shared types, constants and helpers for the downscaled integral image block.
// ----------------------------------------------------------------------------
package dii_pkg;

    // Field widths fixed by the interface
    localparam int PIX_W   = 8;
    localparam int DIM_W   = 13;
    localparam int PART_W  = 14;
    localparam int SUM_W   = 32;
    localparam int COL_W   = 10;
    localparam int SCALE_W = 3;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register word index (paddr[2])
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Frame geometry derived from the registers
    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [DIM_W-1:0]   out_w;
        logic [DIM_W-1:0]   out_h;
    } geom_t;

    // Position of one in-range source pixel
    typedef struct packed {
        logic             first;
        logic             last;
        logic             frame_last;
        logic [DIM_W-1:0] orow;
        logic [DIM_W-1:0] blk;
    } pos_t;

    // Register value of 0 acts as 1
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        eff_dim = (v == '0) ? DIM_W'(1) : v;
    endfunction

    // Smallest s (capped at max_s) with max_w << s >= w; the compares are
    // monotone in s, so s is the count of those that fail
    function automatic logic [SCALE_W-1:0] scale_of(input logic [DIM_W-1:0]   w,
                                                    input logic [DIM_W-1:0]   max_w,
                                                    input logic [SCALE_W-1:0] max_s);
        logic [SCALE_W-1:0] s;
        logic [DIM_W+7:0]   lim;
        s = '0;
        for (int i = 0; i < (1 << SCALE_W) - 1; i++) begin
            lim = (DIM_W+8)'(max_w) << i;
            if (SCALE_W'(i) < max_s && lim < (DIM_W+8)'(w)) begin
                s = s + SCALE_W'(1);
            end
        end
        scale_of = s;
    endfunction

    // Full geometry from the two register values
    function automatic geom_t geom_of(input logic [DIM_W-1:0]   w_raw,
                                      input logic [DIM_W-1:0]   h_raw,
                                      input logic [DIM_W-1:0]   max_w,
                                      input logic [SCALE_W-1:0] max_s);
        geom_t g;
        g.width  = eff_dim(w_raw);
        g.height = eff_dim(h_raw);
        g.scale  = scale_of(g.width, max_w, max_s);
        g.out_w  = g.width >> g.scale;
        if (g.out_w > max_w) begin
            g.out_w = max_w;
        end
        g.out_h  = g.height >> g.scale;
        geom_of  = g;
    endfunction

endpackage

### design/dii_cfg.sv
// ----------------------------------------------------------------------------
// dii_cfg
// APB register file for width and height, with registered frame geometry.
// ----------------------------------------------------------------------------
module dii_cfg #(
    parameter int MAX_OUT_WIDTH  = 960,
    parameter int MAX_SCALE_LOG2 = 3
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dii_pkg::PADDR_W-1:0]  paddr,
    input  logic [dii_pkg::PDATA_W-1:0]  pwdata,
    output logic [dii_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output dii_pkg::geom_t               geom,
    output logic                         restart
);
    import dii_pkg::*;

    localparam logic [DIM_W-1:0]   MaxW = DIM_W'(MAX_OUT_WIDTH);
    localparam logic [SCALE_W-1:0] MaxS = SCALE_W'(MAX_SCALE_LOG2);
    localparam logic [DIM_W-1:0]   WidthRst  = DIM_W'(640);
    localparam logic [DIM_W-1:0]   HeightRst = DIM_W'(480);

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    geom_t            geom_reg;
    logic             wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign restart = wr_en;

    // Register write decode
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en) begin
            case (paddr[2])
                REG_WIDTH:  width_next  = pwdata[DIM_W-1:0];
                REG_HEIGHT: height_next = pwdata[DIM_W-1:0];
                default:    width_next  = width_reg;
            endcase
        end
    end

    // Geometry is registered from the new values, so it updates together with the registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WidthRst;
            height_reg <= HeightRst;
            geom_reg   <= geom_of(WidthRst, HeightRst, MaxW, MaxS);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            geom_reg   <= geom_of(width_next, height_next, MaxW, MaxS);
        end
    end

    // Read back
    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_HEIGHT: prdata = PDATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    assign geom = geom_reg;

endmodule

### design/dii_ram.sv
// ----------------------------------------------------------------------------
// dii_ram
// Simple dual-port RAM, registered read, write data passed through on a
// same-address collision.
// ----------------------------------------------------------------------------
module dii_ram #(
    parameter int DEPTH = 960,
    parameter int WIDTH = 32,
    parameter int AW    = 10
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read sees the write of the same edge
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= (we && waddr == raddr) ? wdata : mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/dii_scan.sv
// ----------------------------------------------------------------------------
// dii_scan
// Source raster counters and block position decode for each incoming item.
// ----------------------------------------------------------------------------
module dii_scan (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           restart,
    input  logic           accept,
    input  dii_pkg::geom_t geom,
    output logic           in_range,
    output dii_pkg::pos_t  pos
);
    import dii_pkg::*;

    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] mask;
    logic [DIM_W-1:0] blk;
    logic [DIM_W-1:0] orow;
    logic [DIM_W:0]   col_inc;
    logic [DIM_W:0]   row_inc;

    // Block decode
    always_comb begin
        mask     = DIM_W'(((DIM_W+1)'(1) << geom.scale) - (DIM_W+1)'(1));
        blk      = col_reg >> geom.scale;
        orow     = row_reg >> geom.scale;
        in_range = (blk < geom.out_w) && (orow < geom.out_h);
        pos.blk  = blk;
        pos.orow = orow;
        pos.first = ((row_reg & mask) == '0) && ((col_reg & mask) == '0);
        pos.last  = ((row_reg & mask) == mask) && ((col_reg & mask) == mask);
        pos.frame_last = (orow == geom.out_h - DIM_W'(1)) &&
                         (blk == geom.out_w - DIM_W'(1));
    end

    // Raster advance with wrap at width and height
    always_comb begin
        col_inc  = (DIM_W+1)'(col_reg) + (DIM_W+1)'(1);
        row_inc  = (DIM_W+1)'(row_reg) + (DIM_W+1)'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (col_inc >= (DIM_W+1)'(geom.width)) begin
                col_next = '0;
                row_next = (row_inc >= (DIM_W+1)'(geom.height)) ? '0 : row_inc[DIM_W-1:0];
            end else begin
                col_next = col_inc[DIM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

### design/dii_accum.sv
// ----------------------------------------------------------------------------
// dii_accum
// Item register, block and row accumulation, and result register.
// ----------------------------------------------------------------------------
module dii_accum #(
    parameter int AW = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        restart,
    input  dii_pkg::geom_t              geom,
    // incoming item
    input  logic                        load,
    input  logic [dii_pkg::PIX_W-1:0]   pix,
    input  dii_pkg::pos_t               pos,
    output logic                        busy_hold,
    // store read data, write ports
    input  logic [dii_pkg::PART_W-1:0]  part_rd,
    input  logic [dii_pkg::SUM_W-1:0]   prev_rd,
    output logic                        part_we,
    output logic                        prev_we,
    output logic [AW-1:0]               waddr,
    output logic [dii_pkg::PART_W-1:0]  part_wd,
    output logic [dii_pkg::SUM_W-1:0]   prev_wd,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [dii_pkg::SUM_W-1:0]   m_integral_value,
    output logic [dii_pkg::DIM_W-1:0]   m_out_row,
    output logic [dii_pkg::COL_W-1:0]   m_out_col,
    output logic                        m_frame_last
);
    import dii_pkg::*;

    logic             a_valid_reg;
    logic [PIX_W-1:0] a_pix_reg;
    pos_t             a_pos_reg;
    logic [SUM_W-1:0] rs_reg, rs_next;
    logic [SUM_W-1:0] row_sum;
    logic [SUM_W-1:0] value;
    logic             advance;
    logic             emit;

    logic             m_valid_reg;
    logic [SUM_W-1:0] m_value_reg;
    logic [DIM_W-1:0] m_row_reg;
    logic [COL_W-1:0] m_col_reg;
    logic             m_last_reg;

    // Stage moves on unless it holds a result and the output is full and not ready
    assign emit      = a_valid_reg & a_pos_reg.last;
    assign advance   = a_valid_reg & (~a_pos_reg.last | ~m_valid_reg | m_ready);
    assign busy_hold = a_valid_reg & ~advance;

    // Block partial, row running sum and integral value
    always_comb begin
        part_wd = a_pos_reg.first ? PART_W'(a_pix_reg) : part_rd + PART_W'(a_pix_reg);
        row_sum = (a_pos_reg.blk == '0) ? SUM_W'(part_wd) : rs_reg + SUM_W'(part_wd);
        value   = (row_sum >> {geom.scale, 1'b0}) +
                  ((a_pos_reg.orow != '0) ? prev_rd : '0);
        prev_wd = value;
        rs_next = rs_reg;
        if (restart) begin
            rs_next = '0;
        end else if (advance && emit) begin
            rs_next = row_sum;
        end
    end

    assign waddr   = a_pos_reg.blk[AW-1:0];
    assign part_we = advance;
    assign prev_we = advance & emit;

    // Item register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            rs_reg      <= '0;
        end else begin
            rs_reg <= rs_next;
            if (load) begin
                a_valid_reg <= 1'b1;
            end else if (advance) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            a_pix_reg <= pix;
            a_pos_reg <= pos;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            m_value_reg <= value;
            m_row_reg   <= a_pos_reg.orow;
            m_col_reg   <= a_pos_reg.blk[COL_W-1:0];
            m_last_reg  <= a_pos_reg.frame_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_integral_value = m_value_reg;
    assign m_out_row        = m_row_reg;
    assign m_out_col        = m_col_reg;
    assign m_frame_last     = m_last_reg;

endmodule

### design/downscaled_integral_image.sv
// ----------------------------------------------------------------------------
// downscaled_integral_image
// Streaming integral image of a power-of-two downscaled gray frame.
// ----------------------------------------------------------------------------
//  channel   ports                               role
//  s_        s_valid/s_ready, s_gray_pixel       source pixels, raster order
//  m_        m_valid/m_ready, m_integral_value,  one item per whole block,
//            m_out_row, m_out_col, m_frame_last  on its bottom-right pixel
//  apb       psel/penable/pwrite/paddr/pwdata    width at 0x0, height at 0x4
//
//  One item per cycle unless stalled: the item register, the store read and
//  the result register form two stages that a pixel passes through in order.
//  The per-column stores read as an in-range item loads, write back as it leaves
//  the item register; a write-through read covers back-to-back same-column items.
//  Reset is synchronous; no clearing pass, the stores are written before read.
//  A full result register with m_ready low stalls only items that end a block.
// ----------------------------------------------------------------------------
module downscaled_integral_image #(
    parameter int MAX_OUT_WIDTH  = 960,
    parameter int MAX_SCALE_LOG2 = 3
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // source items
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [dii_pkg::PIX_W-1:0]    s_gray_pixel,
    // result items
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [dii_pkg::SUM_W-1:0]    m_integral_value,
    output logic [dii_pkg::DIM_W-1:0]    m_out_row,
    output logic [dii_pkg::COL_W-1:0]    m_out_col,
    output logic                         m_frame_last,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dii_pkg::PADDR_W-1:0]  paddr,
    input  logic [dii_pkg::PDATA_W-1:0]  pwdata,
    output logic [dii_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import dii_pkg::*;

    localparam int AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

    geom_t             geom;
    pos_t              pos;
    logic              restart;
    logic              in_range;
    logic              accept;
    logic              load;
    logic              busy_hold;
    logic [PART_W-1:0] part_rd, part_wd;
    logic [SUM_W-1:0]  prev_rd, prev_wd;
    logic              part_we, prev_we;
    logic [AW-1:0]     waddr;

    // No item is taken while reset is held
    assign s_ready = aresetn & ~busy_hold;
    assign accept  = s_valid & s_ready;
    assign load    = accept & in_range;

    dii_cfg #(
        .MAX_OUT_WIDTH  (MAX_OUT_WIDTH),
        .MAX_SCALE_LOG2 (MAX_SCALE_LOG2)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom),
        .restart (restart)
    );

    dii_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (restart),
        .accept   (accept),
        .geom     (geom),
        .in_range (in_range),
        .pos      (pos)
    );

    // Per-column block partial sums
    dii_ram #(
        .DEPTH (MAX_OUT_WIDTH),
        .WIDTH (PART_W),
        .AW    (AW)
    ) u_part_ram (
        .aclk  (aclk),
        .we    (part_we),
        .waddr (waddr),
        .wdata (part_wd),
        .re    (load),
        .raddr (pos.blk[AW-1:0]),
        .rdata (part_rd)
    );

    // Previous output row integral
    dii_ram #(
        .DEPTH (MAX_OUT_WIDTH),
        .WIDTH (SUM_W),
        .AW    (AW)
    ) u_prev_ram (
        .aclk  (aclk),
        .we    (prev_we),
        .waddr (waddr),
        .wdata (prev_wd),
        .re    (load),
        .raddr (pos.blk[AW-1:0]),
        .rdata (prev_rd)
    );

    dii_accum #(
        .AW (AW)
    ) u_accum (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .restart          (restart),
        .geom             (geom),
        .load             (load),
        .pix              (s_gray_pixel),
        .pos              (pos),
        .busy_hold        (busy_hold),
        .part_rd          (part_rd),
        .prev_rd          (prev_rd),
        .part_we          (part_we),
        .prev_we          (prev_we),
        .waddr            (waddr),
        .part_wd          (part_wd),
        .prev_wd          (prev_wd),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_integral_value (m_integral_value),
        .m_out_row        (m_out_row),
        .m_out_col        (m_out_col),
        .m_frame_last     (m_frame_last)
    );

endmodule

### tb/downscaled_integral_image_checker.sv
// ----------------------------------------------------------------------------
// downscaled_integral_image_checker
// Watches the pixel, result and register ports of the downscaled integral
// image block, predicts every result item from the accepted pixels and
// compares the results field by field in arrival order.
// ----------------------------------------------------------------------------
module downscaled_integral_image_checker #(
    parameter int MAX_OUT_WIDTH  = 960,
    parameter int MAX_SCALE_LOG2 = 3
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [dii_pkg::PIX_W-1:0]    s_gray_pixel,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [dii_pkg::SUM_W-1:0]    m_integral_value,
    input  logic [dii_pkg::DIM_W-1:0]    m_out_row,
    input  logic [dii_pkg::COL_W-1:0]    m_out_col,
    input  logic                         m_frame_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dii_pkg::PADDR_W-1:0]  paddr,
    input  logic [dii_pkg::PDATA_W-1:0]  pwdata,
    input  logic                         pready,
    output int                           mismatches,
    output int                           results_due
);
    import dii_pkg::*;

    localparam int MAX_PRINT = 100;

    typedef struct {
        logic [SUM_W-1:0] value;
        logic [DIM_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } integral_result_t;

    // Shadow registers and frame position
    logic [DIM_W-1:0]  cfg_width;
    logic [DIM_W-1:0]  cfg_height;
    int unsigned       src_col;
    int unsigned       src_row;
    logic [SUM_W-1:0]  row_sum;
    logic [PART_W-1:0] block_acc [MAX_OUT_WIDTH];
    logic [SUM_W-1:0]  above_row [MAX_OUT_WIDTH];

    integral_result_t  integral_due [$];
    integral_result_t  want;

    initial begin
        mismatches  = 0;
        results_due = 0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINT) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // One source pixel: accumulate its block, emit on the bottom-right pixel
    task automatic predict_integral(input logic [PIX_W-1:0] pix);
        int unsigned      w;
        int unsigned      h;
        int unsigned      s;
        int unsigned      mask;
        int unsigned      ow;
        int unsigned      oh;
        int unsigned      blk;
        int unsigned      orow;
        logic [PART_W-1:0] part;
        logic [SUM_W-1:0] val;
        integral_result_t res;
        w = (cfg_width == '0) ? 1 : cfg_width;
        h = (cfg_height == '0) ? 1 : cfg_height;
        s = 0;
        while (s < MAX_SCALE_LOG2 && (MAX_OUT_WIDTH << s) < w) begin
            s++;
        end
        mask = (1 << s) - 1;
        ow   = w >> s;
        if (ow > MAX_OUT_WIDTH) begin
            ow = MAX_OUT_WIDTH;
        end
        oh = h >> s;
        if ((src_col >> s) < ow && (src_row >> s) < oh) begin
            blk  = src_col >> s;
            orow = src_row >> s;
            if ((src_row & mask) == 0 && (src_col & mask) == 0) begin
                part = PART_W'(pix);
            end else begin
                part = block_acc[blk] + PART_W'(pix);
            end
            block_acc[blk] = part;
            if ((src_row & mask) == mask && (src_col & mask) == mask) begin
                if (blk == 0) begin
                    row_sum = SUM_W'(part);
                end else begin
                    row_sum = row_sum + SUM_W'(part);
                end
                val = row_sum >> (2 * s);
                if (orow > 0) begin
                    val = val + above_row[blk];
                end
                above_row[blk] = val;
                res.value = val;
                res.row   = DIM_W'(orow);
                res.col   = COL_W'(blk);
                res.last  = (orow == oh - 1) && (blk == ow - 1);
                integral_due.push_back(res);
            end
        end
        // Advance the raster position, wrapping at the frame end
        if (src_col + 1 >= w) begin
            src_col = 0;
            src_row = (src_row + 1 >= h) ? 0 : src_row + 1;
        end else begin
            src_col = src_col + 1;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width  = DIM_W'(640);
            cfg_height = DIM_W'(480);
            src_col    = 0;
            src_row    = 0;
            row_sum    = '0;
            integral_due.delete();
        end else begin
            // Result items against the oldest expectation
            if (m_valid && m_ready) begin
                if (integral_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected item row %0d col %0d value %0h",
                                              m_out_row, m_out_col, m_integral_value));
                end else begin
                    want = integral_due.pop_front();
                    if (m_integral_value !== want.value) begin
                        report_mismatch($sformatf("value %0h, want %0h (row %0d col %0d)",
                                                  m_integral_value, want.value,
                                                  want.row, want.col));
                    end
                    if (m_out_row !== want.row) begin
                        report_mismatch($sformatf("out_row %0d, want %0d",
                                                  m_out_row, want.row));
                    end
                    if (m_out_col !== want.col) begin
                        report_mismatch($sformatf("out_col %0d, want %0d",
                                                  m_out_col, want.col));
                    end
                    if (m_frame_last !== want.last) begin
                        report_mismatch($sformatf("frame_last %0b, want %0b (row %0d col %0d)",
                                                  m_frame_last, want.last,
                                                  want.row, want.col));
                    end
                end
            end
            // Register writes restart the frame
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_WIDTH) begin
                    cfg_width = pwdata[DIM_W-1:0];
                end else begin
                    cfg_height = pwdata[DIM_W-1:0];
                end
                src_col = 0;
                src_row = 0;
                row_sum = '0;
            end
            if (s_valid && s_ready) begin
                predict_integral(s_gray_pixel);
            end
        end
        results_due <= integral_due.size();
    end

endmodule

### tb/downscaled_integral_image_tb.sv
// ----------------------------------------------------------------------------
// downscaled_integral_image_tb
// Drives source pixels and register writes into the downscaled integral image
// block under random idling on both channels; the checker beside the block
// predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module downscaled_integral_image_tb;
    import dii_pkg::*;

    localparam int RAND_ITEMS     = 290;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int TIMEOUT_CYCLES = 1_500_000;

    logic                aclk         = 1'b0;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [PIX_W-1:0]    s_gray_pixel = '0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic [SUM_W-1:0]    m_integral_value;
    logic [DIM_W-1:0]    m_out_row;
    logic [COL_W-1:0]    m_out_col;
    logic                m_frame_last;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int  mismatches;
    int  results_due;

    // Idling controls for the source task and the sink process
    bit  src_gaps_on = 1'b1;
    bit  snk_gaps_on = 1'b1;
    int  hold_requests = 0;

    int  rand_items;
    int  n;
    int  frame_px;
    bit  first_pass;
    logic [DIM_W-1:0] cur_w;
    logic [DIM_W-1:0] cur_h;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    downscaled_integral_image dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_gray_pixel     (s_gray_pixel),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_integral_value (m_integral_value),
        .m_out_row        (m_out_row),
        .m_out_col        (m_out_col),
        .m_frame_last     (m_frame_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    downscaled_integral_image_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_gray_pixel     (s_gray_pixel),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_integral_value (m_integral_value),
        .m_out_row        (m_out_row),
        .m_out_col        (m_out_col),
        .m_frame_last     (m_frame_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .mismatches       (mismatches),
        .results_due      (results_due)
    );

    // Run limit
    initial begin
        #(TIMEOUT_CYCLES * 8);
        $display("TB_ERROR");
        $finish;
    end

    // Result sink: random stall per item, long hold-offs on request
    initial begin
        int stall;
        int holds_done;
        holds_done = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (holds_done != hold_requests) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end
            stall = snk_gaps_on ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // One pixel item: optional gap, then hold valid until accepted
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_gray_pixel <= pix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Mostly random pixels, with the extremes now and then
    function automatic logic [PIX_W-1:0] draw_pixel();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end
        return PIX_W'($urandom);
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_pixel(draw_pixel());
    endtask

    // Stop offering and wait for every expected result, then the pipeline
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register write: setup then access; upper data bits are random
    task automatic apb_write(input logic idx, input logic [DIM_W-1:0] val);
        logic [PDATA_W-1:0] data;
        data          = $urandom;
        data[DIM_W-1:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        wait_idle();
        if ($urandom_range(0, 1) == 0) begin
            apb_write(REG_WIDTH, w);
            apb_write(REG_HEIGHT, h);
        end else begin
            apb_write(REG_HEIGHT, h);
            apb_write(REG_WIDTH, w);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset geometry, extremes of the pixel
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h55);
        send_pixel(8'hAA);
        send_pixel(8'h01);
        send_pixel(8'h80);

        // Zero registers act as one: every pixel is a whole frame
        set_geometry('0, '0);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h03);

        // Two by two frame, then a wrap into the next frame
        set_geometry(DIM_W'(2), DIM_W'(2));
        repeat (5) send_pixel(8'hFF);

        // Just past one scale step with one source row: nothing is emitted
        set_geometry(DIM_W'(961), DIM_W'(1));
        repeat (3) send_pixel(draw_pixel());

        // Widest register value with too few rows for a block
        set_geometry('1, DIM_W'(2));
        repeat (3) send_pixel(draw_pixel());

        // Long receiver hold-off while the source streams
        set_geometry(DIM_W'(20), DIM_W'(10));
        src_gaps_on = 1'b0;
        hold_requests++;
        send_random(100);
        // Sender pause mid-frame until all results are in
        wait_idle();
        send_random(100);
        src_gaps_on = 1'b1;

        // Random part: small frames, whole or broken off
        rand_items = 0;
        first_pass = 1'b1;
        cur_w      = '0;
        cur_h      = '0;
        while (rand_items < RAND_ITEMS) begin
            src_gaps_on = ($urandom_range(0, 3) != 0);
            snk_gaps_on = ($urandom_range(0, 3) != 0);
            wait_idle();
            if (first_pass || $urandom_range(0, 3) != 0) begin
                cur_w = DIM_W'($urandom_range(1, 24));
                cur_h = DIM_W'($urandom_range(1, 12));
                if ($urandom_range(0, 7) == 0) cur_w = '0;
                if ($urandom_range(0, 7) == 0) cur_h = '0;
                if ($urandom_range(0, 1) == 0) begin
                    apb_write(REG_WIDTH, cur_w);
                    apb_write(REG_HEIGHT, cur_h);
                end else begin
                    apb_write(REG_HEIGHT, cur_h);
                    apb_write(REG_WIDTH, cur_w);
                end
            end else if ($urandom_range(0, 1) == 0) begin
                cur_w = DIM_W'($urandom_range(1, 24));
                apb_write(REG_WIDTH, cur_w);
            end else begin
                cur_h = DIM_W'($urandom_range(1, 12));
                apb_write(REG_HEIGHT, cur_h);
            end
            first_pass = 1'b0;
            frame_px = ((cur_w == '0) ? 1 : int'(cur_w)) * ((cur_h == '0) ? 1 : int'(cur_h));
            n = frame_px * $urandom_range(1, 2);
            if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, frame_px);
            end
            // Keep the random part to its item budget
            if (n > RAND_ITEMS - rand_items) begin
                n = RAND_ITEMS - rand_items;
            end
            repeat (n) begin
                send_pixel(draw_pixel());
                rand_items++;
            end
        end
        src_gaps_on = 1'b1;
        snk_gaps_on = 1'b1;

        // Tallest register value, narrow rows, part of a frame
        set_geometry(DIM_W'(4), '1);
        send_random(40);

        wait_idle();
        if (mismatches == 0 && results_due == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
